>>> hw/rtl/skvt_pkg.sv
// shared types and constants of the sorted key/value table
package skvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  // contents of one slot as handed between neighbors
  typedef struct packed {
    logic   valid;
    key_t   key;
    value_t value;
  } entry_t;

  // operation broadcast to every cell in the execute cycle
  typedef struct packed {
    logic   exec;
    cmd_t   cmd;
    key_t   key;
    value_t value;
    logic   hit;
    logic   full;
  } ctrl_t;

  // compare outcome of one cell
  typedef struct packed {
    logic after;  // slot is empty or holds a key >= the operand key
    logic eq;     // slot is valid and holds the operand key
  } flags_t;

endpackage

>>> hw/rtl/skvt_if.sv
// valid/ready channel interfaces for commands and results
interface skvt_in_if;
  import skvt_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  key_t   key;
  value_t value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface skvt_out_if;
  import skvt_pkg::*;

  logic   valid;
  logic   ready;
  logic   found;
  value_t value_out;
  logic   status;

  modport source (output valid, output found, output value_out, output status, input ready);
  modport sink   (input valid, input found, input value_out, input status, output ready);
endinterface

>>> hw/rtl/skvt_cell.sv
// one slot of the sorted table: compares, updates or shifts up on insert, shifts down on remove
module skvt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  skvt_pkg::ctrl_t  ctrl,
  input  skvt_pkg::entry_t prev_entry,
  input  logic            prev_after,
  input  skvt_pkg::entry_t next_entry,
  output skvt_pkg::entry_t entry,
  output skvt_pkg::flags_t flags
);
  import skvt_pkg::*;

  logic   valid_r, valid_nxt;
  key_t   key_r, key_nxt;
  value_t value_r, value_nxt;

  assign entry = '{valid: valid_r, key: key_r, value: value_r};

  always_comb begin
    flags.after = !valid_r || (key_r >= ctrl.key);
    flags.eq    = valid_r && (key_r == ctrl.key);
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.exec) begin
      unique case (ctrl.cmd)
        CMD_INSERT: begin
          if (ctrl.hit) begin
            if (flags.eq) begin
              value_nxt = ctrl.value;
            end
          end else if (!ctrl.full && flags.after) begin
            // first slot at or past the new key takes it, the rest move up
            if (prev_after) begin
              valid_nxt = prev_entry.valid;
              key_nxt   = prev_entry.key;
              value_nxt = prev_entry.value;
            end else begin
              valid_nxt = 1'b1;
              key_nxt   = ctrl.key;
              value_nxt = ctrl.value;
            end
          end
        end
        CMD_REMOVE: begin
          // the hit slot and everything above it move down one
          if (ctrl.hit && flags.after) begin
            valid_nxt = next_entry.valid;
            key_nxt   = next_entry.key;
            value_nxt = next_entry.value;
          end
        end
        CMD_FIND, CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

>>> hw/rtl/sorted_key_value_table.sv
// top level of the sorted key/value table: operand capture, cell row, result register
//
//  port    dir  carries
//  in_ch   in   command, key, value (one operation per beat)
//  out_ch  out  found, value_out, status (one result per beat)
//
// each operation first captures the beat into the operand registers; then, in the
// execute cycle, every cell compares its key and the whole row shifts or updates at once.
// a new beat is taken while the previous result waits in the output register;
// the execute cycle waits until that register is free.
// synchronous active-low reset empties the table; key and value slots stay
// unset until written and are never read while empty.
module sorted_key_value_table (
  input  logic clk,
  input  logic rst_n,
  skvt_in_if.sink    in_ch,
  skvt_out_if.source out_ch
);
  import skvt_pkg::*;

  logic   busy_r;
  cmd_t   cmd_r;
  key_t   key_r;
  value_t value_r;

  logic   out_valid_r;
  logic   found_r;
  value_t value_out_r;
  logic   status_r;

  ctrl_t  ctrl;
  entry_t entries   [TABLE_DEPTH];
  flags_t flags     [TABLE_DEPTH];
  logic   [TABLE_DEPTH-1:0] eq_vec;
  logic   [TABLE_DEPTH-1:0] valid_vec;
  logic   exec;
  value_t hit_value;

  assign in_ch.ready = !busy_r;
  assign exec        = busy_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      eq_vec[i]    = flags[i].eq;
      valid_vec[i] = entries[i].valid;
    end
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (eq_vec[i]) begin
        hit_value = hit_value | entries[i].value;
      end
    end
  end

  always_comb begin
    ctrl.exec  = exec;
    ctrl.cmd   = cmd_r;
    ctrl.key   = key_r;
    ctrl.value = value_r;
    ctrl.hit   = |eq_vec;
    ctrl.full  = entries[TABLE_DEPTH-1].valid;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_a;

    if (g == 0) begin : g_head
      assign prev_e = '0;
      assign prev_a = 1'b0;
    end else begin : g_mid
      assign prev_e = entries[g-1];
      assign prev_a = flags[g-1].after;
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_low
      assign next_e = entries[g+1];
    end

    skvt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_entry (prev_e),
      .prev_after (prev_a),
      .next_entry (next_e),
      .entry      (entries[g]),
      .flags      (flags[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r   <= in_ch.command;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (cmd_r)
        CMD_INSERT, CMD_REMOVE, CMD_FIND: begin
          found_r     <= ctrl.hit;
          value_out_r <= hit_value;
          status_r    <= (cmd_r == CMD_INSERT) && !ctrl.hit && ctrl.full;
        end
        CMD_NOP: begin
          found_r     <= 1'b0;
          value_out_r <= '0;
          status_r    <= 1'b0;
        end
        default: begin
          found_r     <= 1'b0;
          value_out_r <= '0;
          status_r    <= 1'b0;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = found_r;
  assign out_ch.value_out = value_out_r;
  assign out_ch.status    = status_r;

  a_rose_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result beat without an executed operation");

  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(status_r && found_r))
    else $error("full flag raised on a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> value_out_r == '0)
    else $error("nonzero value on a miss");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> valid_vec == '0)
    else $error("table not empty after reset");

  for (genvar s = 0; s < TABLE_DEPTH - 1; s++) begin : g_chk
    a_sorted_packed: assert property (@(posedge clk) disable iff (!rst_n)
      valid_vec[s+1] |-> valid_vec[s] && (entries[s].key < entries[s+1].key))
      else $error("table not packed or not sorted");
  end

endmodule

>>> bench/tb_sorted_key_value_table.sv
// testbench for the sorted key/value table: directed and random commands checked against a table model
module tb_sorted_key_value_table;
  import skvt_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic   found;
    value_t value_out;
    logic   status;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n;

  skvt_in_if  in_ch ();
  skvt_out_if out_ch ();

  sorted_key_value_table DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // table model, kept sorted and packed from slot 0
  key_t   model_keys [TABLE_DEPTH];
  value_t model_values [TABLE_DEPTH];
  int     model_count = 0;

  lookup_result_t pending_results[$];
  int   error_count  = 0;
  int   quiet_cycles = 0;
  int   hold_request = 0;
  bit   idle_in      = 1'b0;
  bit   idle_out     = 1'b0;
  key_t key_pool [POOL_SIZE];

  always #6 clk = ~clk;

  function automatic lookup_result_t model_table_op(cmd_t op, key_t k, value_t v);
    lookup_result_t r;
    int pos;
    bit hit;
    r   = '0;
    pos = model_count;
    hit = 1'b0;
    for (int i = 0; i < model_count; i++) begin
      if (model_keys[i] >= k) begin
        pos = i;
        hit = (model_keys[i] == k);
        break;
      end
    end
    case (op)
      CMD_INSERT: begin
        if (hit) begin
          r.found          = 1'b1;
          r.value_out      = model_values[pos];
          model_values[pos] = v;
        end else if (model_count >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          for (int i = model_count; i > pos; i--) begin
            model_keys[i]   = model_keys[i-1];
            model_values[i] = model_values[i-1];
          end
          model_keys[pos]   = k;
          model_values[pos] = v;
          model_count++;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          r.found     = 1'b1;
          r.value_out = model_values[pos];
          for (int i = pos; i < model_count - 1; i++) begin
            model_keys[i]   = model_keys[i+1];
            model_values[i] = model_values[i+1];
          end
          model_count--;
        end
      end
      CMD_FIND: begin
        if (hit) begin
          r.found     = 1'b1;
          r.value_out = model_values[pos];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one command beat; valid stays high when the next call follows without a gap
  task automatic send_op(cmd_t op, key_t k, value_t v);
    int gap;
    gap = idle_in ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= op;
    in_ch.key     <= k;
    in_ch.value   <= v;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(model_table_op(op, k, v));
  endtask

  // valid is only high right after a send, and then something is pending
  task automatic wait_for_results();
    if (pending_results.size() != 0) begin
      in_ch.valid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_ops();
    send_op(CMD_FIND,   16'h0000, 32'h0000_0000);   // empty table
    send_op(CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(CMD_NOP,    16'h1234, 32'hDEAD_BEEF);
    send_op(CMD_INSERT, 16'h8000, 32'h0000_0001);
    send_op(CMD_INSERT, 16'h0000, 32'hFFFF_FFFF);   // new head
    send_op(CMD_INSERT, 16'hFFFF, 32'h0000_0000);   // new tail
    send_op(CMD_INSERT, 16'h4000, 32'hA5A5_5A5A);
    send_op(CMD_INSERT, 16'h0000, 32'h5555_AAAA);   // replace at head
    send_op(CMD_FIND,   16'hFFFF, 32'h0000_0000);
    send_op(CMD_FIND,   16'h4001, 32'h0000_0000);   // miss between entries
    send_op(CMD_REMOVE, 16'h0000, 32'h0000_0000);   // head removal
    send_op(CMD_FIND,   16'h0000, 32'h0000_0000);
    send_op(CMD_REMOVE, 16'hFFFF, 32'h0000_0000);
    send_op(CMD_REMOVE, 16'h8001, 32'h0000_0000);
    wait_for_results();
  endtask

  task automatic test_full_table();
    // descending keys, each landing below the keys inserted before it
    for (int i = 13; i >= 0; i--)
      send_op(CMD_INSERT, key_t'(i * 16'h1111 + 16'h0005), value_t'($urandom));
    send_op(CMD_INSERT, 16'h7FFF, 32'h1234_5678);   // refused, table full
    send_op(CMD_INSERT, 16'h8000, 32'h8765_4321);   // replace still allowed
    send_op(CMD_FIND,   16'h4000, 32'h0000_0000);
    send_op(CMD_REMOVE, 16'h0005, 32'h0000_0000);
    send_op(CMD_INSERT, 16'h0001, 32'hFFFF_FFFF);
    send_op(CMD_INSERT, 16'hFFFF, 32'h0000_0000);   // refused again
    wait_for_results();
  endtask

  task automatic test_random_ops(int count, int insert_pct, int remove_pct);
    int   r;
    cmd_t op;
    key_t k;
    value_t v;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct)                   op = CMD_INSERT;
      else if (r < insert_pct + remove_pct) op = CMD_REMOVE;
      else if (r < 97)                      op = CMD_FIND;
      else                                  op = CMD_NOP;
      // mostly pool keys so that hits, replaces and a full table are common
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else                            k = key_t'($urandom);
      case ($urandom_range(0, 19))
        0:       v = '0;
        1:       v = '1;
        default: v = value_t'($urandom);
      endcase
      send_op(op, k, v);
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    wait_for_results();
    idle_in      = 1'b0;
    hold_request = 160;
    test_random_ops(30, 45, 25);
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = idle_out ? $urandom_range(0, 12) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(out_ch.valid && out_ch.ready) && hold_request == 0);
    end
  end

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: found %0d value_out %h status %0d",
               out_ch.found, out_ch.value_out, out_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_ch.found);
          error_count++;
        end
        if (out_ch.value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, out_ch.value_out);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  // ends the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL sorted_key_value_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_NOP;
    in_ch.key     <= '0;
    in_ch.value   <= '0;
    // edge keys, a tight cluster, and scattered keys
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'h0001;
    key_pool[2] = 16'hFFFE;
    key_pool[3] = 16'hFFFF;
    for (int i = 4; i < 12; i++) key_pool[i] = key_t'(16'h7FF8 + i);
    for (int i = 12; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    test_full_table();
    test_random_ops(100, 45, 25);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    test_random_ops(80, 40, 30);
    idle_in  = 1'b1;
    test_random_ops(80, 25, 45);
    idle_in  = 1'b0;
    idle_out = 1'b1;
    test_random_ops(80, 60, 15);
    test_backpressure();
    idle_in  = 1'b1;
    test_random_ops(60, 40, 30);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS sorted_key_value_table");
    end else begin
      $display("FAIL sorted_key_value_table");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_if.sv
hw/rtl/skvt_cell.sv
hw/rtl/sorted_key_value_table.sv
bench/tb_sorted_key_value_table.sv
